// ===== hdl/mdpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mdpq_pkg
// Shared constants, types and helpers of the minimum-distance priority queue.
// ----------------------------------------------------------------------------
package mdpq_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int CMD_W    = 3;
	localparam int KEY_W    = 32;
	localparam int ID_W     = 32;
	localparam int STAMP_W  = 32;
	localparam int STATUS_W = 2;

	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [ID_W-1:0]    id;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH,
		ST_INSERT,
		ST_RESP
	} state_t;

	// lowest-numbered slot whose valid bit is clear
	function automatic logic [ADDR_W-1:0] first_free(input logic [CAPACITY-1:0] valid);
		logic [ADDR_W-1:0] slot;
		slot = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!valid[i]) begin
				slot = ADDR_W'(i);
			end
		end
		return slot;
	endfunction

endpackage

// ===== hdl/min_distance_priority_queue.sv =====
// ----------------------------------------------------------------------------
// min_distance_priority_queue
// Distance-keyed priority queue of ids with insert, remove, pop minimum,
// update and count at distance. Entries live in one RAM, valid bits in flops.
//
//   port group   dir  handshake            payload
//   input item   in   in_valid/in_ready    command, distance, new_distance,
//                                          item_id
//   result item  out  out_valid/out_ready  status, popped_distance, popped_id,
//                                          key_count, total_count, is_empty
//
// Insert writes the RAM in ST_INSERT, then loads the result in ST_RESP;
// insert when full and unknown commands go straight to ST_RESP.
// Remove, pop and count scan every slot, one RAM read per slot through
// one read port, then finish. Update scans, then re-inserts.
// Reset clears valid bits, counters and stamp at once; no clearing pass.
// A new item is accepted once the previous result sits in the output
// register; a stalled output holds the next result in its last state.
// ----------------------------------------------------------------------------
module min_distance_priority_queue (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [mdpq_pkg::CMD_W-1:0]           command,
	input  logic [mdpq_pkg::KEY_W-1:0]           distance,
	input  logic [mdpq_pkg::KEY_W-1:0]           new_distance,
	input  logic [mdpq_pkg::ID_W-1:0]            item_id,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [mdpq_pkg::STATUS_W-1:0]        status,
	output logic [mdpq_pkg::KEY_W-1:0]           popped_distance,
	output logic [mdpq_pkg::ID_W-1:0]            popped_id,
	output logic [mdpq_pkg::CNT_W-1:0]           key_count,
	output logic [mdpq_pkg::CNT_W-1:0]           total_count,
	output logic                                 is_empty
);

	mdpq_pkg::state_t state_q, state_d;

	// control
	logic [mdpq_pkg::CAPACITY-1:0] valid_q;
	logic [mdpq_pkg::CNT_W-1:0]    count_q;
	logic [mdpq_pkg::STAMP_W-1:0]  stamp_q;
	logic [mdpq_pkg::ADDR_W-1:0]   addr_q;
	logic                          issued_all_q;
	logic                          rd_pend_s1;
	logic                          found_q;
	logic [mdpq_pkg::CNT_W-1:0]    kcount_q;
	logic                          out_valid_q;

	// payload
	logic [mdpq_pkg::CMD_W-1:0]    cmd_q;
	logic [mdpq_pkg::KEY_W-1:0]    dist_q;
	logic [mdpq_pkg::KEY_W-1:0]    ndist_q;
	logic [mdpq_pkg::ID_W-1:0]     id_q;
	logic [mdpq_pkg::STATUS_W-1:0] status_q;
	logic [mdpq_pkg::ADDR_W-1:0]   slot_s1;
	logic [mdpq_pkg::ADDR_W-1:0]   best_slot_q;
	logic [mdpq_pkg::STAMP_W-1:0]  best_age_q;
	logic [mdpq_pkg::KEY_W-1:0]    best_dist_q;
	logic [mdpq_pkg::ID_W-1:0]     best_id_q;
	logic [mdpq_pkg::STATUS_W-1:0] out_status_q;
	logic [mdpq_pkg::KEY_W-1:0]    out_pdist_q;
	logic [mdpq_pkg::ID_W-1:0]     out_pid_q;
	logic [mdpq_pkg::CNT_W-1:0]    out_kcount_q;
	logic [mdpq_pkg::CNT_W-1:0]    out_total_q;
	logic                          out_empty_q;

	// fsm outputs
	logic accept;
	logic is_full;
	logic ram_re;
	logic ram_we;
	logic resp_load;
	logic scan_last;

	// ram
	logic [mdpq_pkg::ADDR_W-1:0]  wr_addr;
	logic [mdpq_pkg::ENTRY_W-1:0] rd_data;
	mdpq_pkg::entry_t             rd_entry;
	mdpq_pkg::entry_t             wr_entry;

	// scan compare
	logic [mdpq_pkg::STAMP_W-1:0] age;
	logic                         ent_valid;
	logic                         key_hit;
	logic                         older;
	logic                         take;
	logic                         count_hit;

	assign is_full   = (count_q >= mdpq_pkg::CNT_W'(mdpq_pkg::CAPACITY));
	assign scan_last = rd_pend_s1 && (slot_s1 == mdpq_pkg::ADDR_W'(mdpq_pkg::CAPACITY - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mdpq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		accept    = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		resp_load = 1'b0;
		unique case (state_q)
			mdpq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					accept = 1'b1;
					unique case (command)
						mdpq_pkg::CMD_INSERT: begin
							state_d = is_full ? mdpq_pkg::ST_RESP : mdpq_pkg::ST_INSERT;
						end
						mdpq_pkg::CMD_REMOVE,
						mdpq_pkg::CMD_POP,
						mdpq_pkg::CMD_UPDATE,
						mdpq_pkg::CMD_COUNT: begin
							state_d = mdpq_pkg::ST_SCAN;
						end
						default: begin
							state_d = mdpq_pkg::ST_RESP;
						end
					endcase
				end
			end
			mdpq_pkg::ST_SCAN: begin
				ram_re = !issued_all_q;
				if (scan_last) begin
					state_d = mdpq_pkg::ST_FINISH;
				end
			end
			mdpq_pkg::ST_FINISH: begin
				if (cmd_q == mdpq_pkg::CMD_UPDATE && found_q) begin
					state_d = mdpq_pkg::ST_INSERT;
				end else begin
					state_d = mdpq_pkg::ST_RESP;
				end
			end
			mdpq_pkg::ST_INSERT: begin
				ram_we  = 1'b1;
				state_d = mdpq_pkg::ST_RESP;
			end
			mdpq_pkg::ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					resp_load = 1'b1;
					state_d   = mdpq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mdpq_pkg::ST_IDLE;
			end
		endcase
	end

	assign wr_addr        = mdpq_pkg::first_free(valid_q);
	assign wr_entry.key   = (cmd_q == mdpq_pkg::CMD_UPDATE) ? ndist_q : dist_q;
	assign wr_entry.id    = id_q;
	assign wr_entry.stamp = stamp_q;

	mdpq_ram #(
		.WIDTH (mdpq_pkg::ENTRY_W),
		.DEPTH (mdpq_pkg::CAPACITY)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_en   (ram_re),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	assign rd_entry  = rd_data;
	assign age       = stamp_q - rd_entry.stamp;
	assign ent_valid = rd_pend_s1 && valid_q[slot_s1];
	assign key_hit   = (rd_entry.key == dist_q);
	assign older     = (age > best_age_q);
	assign count_hit = ent_valid && (cmd_q == mdpq_pkg::CMD_COUNT) && key_hit;

	always_comb begin
		take = 1'b0;
		if (ent_valid) begin
			if (cmd_q == mdpq_pkg::CMD_POP) begin
				take = !found_q || (rd_entry.key < best_dist_q) ||
					(key_hit && rd_entry.key == best_dist_q && older) ||
					(rd_entry.key == best_dist_q && older);
			end else if (cmd_q == mdpq_pkg::CMD_REMOVE || cmd_q == mdpq_pkg::CMD_UPDATE) begin
				take = key_hit && (rd_entry.id == id_q) && (!found_q || older);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			count_q      <= '0;
			stamp_q      <= '0;
			addr_q       <= '0;
			issued_all_q <= 1'b0;
			rd_pend_s1   <= 1'b0;
			found_q      <= 1'b0;
			kcount_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				addr_q       <= '0;
				issued_all_q <= 1'b0;
				found_q      <= 1'b0;
				kcount_q     <= '0;
			end
			rd_pend_s1 <= ram_re;
			if (ram_re) begin
				addr_q <= addr_q + mdpq_pkg::ADDR_W'(1);
				if (addr_q == mdpq_pkg::ADDR_W'(mdpq_pkg::CAPACITY - 1)) begin
					issued_all_q <= 1'b1;
				end
			end
			if (take) begin
				found_q <= 1'b1;
			end
			if (count_hit) begin
				kcount_q <= kcount_q + mdpq_pkg::CNT_W'(1);
			end
			if (state_q == mdpq_pkg::ST_FINISH && found_q) begin
				valid_q[best_slot_q] <= 1'b0;
				count_q              <= count_q - mdpq_pkg::CNT_W'(1);
			end
			if (ram_we) begin
				valid_q[wr_addr] <= 1'b1;
				count_q          <= count_q + mdpq_pkg::CNT_W'(1);
				stamp_q          <= stamp_q + mdpq_pkg::STAMP_W'(1);
			end
			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= command;
			dist_q   <= distance;
			ndist_q  <= new_distance;
			id_q     <= item_id;
			status_q <= (command == mdpq_pkg::CMD_INSERT && is_full) ?
				mdpq_pkg::STATUS_FULL : mdpq_pkg::STATUS_OK;
		end
		if (ram_re) begin
			slot_s1 <= addr_q;
		end
		if (take) begin
			best_slot_q <= slot_s1;
			best_age_q  <= age;
			best_dist_q <= rd_entry.key;
			best_id_q   <= rd_entry.id;
		end
		if (state_q == mdpq_pkg::ST_FINISH) begin
			if (found_q || cmd_q == mdpq_pkg::CMD_COUNT) begin
				status_q <= mdpq_pkg::STATUS_OK;
			end else if (cmd_q == mdpq_pkg::CMD_POP) begin
				status_q <= mdpq_pkg::STATUS_EMPTY;
			end else begin
				status_q <= mdpq_pkg::STATUS_NOT_FOUND;
			end
		end
		if (resp_load) begin
			out_status_q <= status_q;
			out_pdist_q  <= (cmd_q == mdpq_pkg::CMD_POP && found_q) ? best_dist_q : '0;
			out_pid_q    <= (cmd_q == mdpq_pkg::CMD_POP && found_q) ? best_id_q : '0;
			out_kcount_q <= (cmd_q == mdpq_pkg::CMD_COUNT) ? kcount_q : '0;
			out_total_q  <= count_q;
			out_empty_q  <= (count_q == '0);
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign popped_distance = out_pdist_q;
	assign popped_id       = out_pid_q;
	assign key_count       = out_kcount_q;
	assign total_count     = out_total_q;
	assign is_empty        = out_empty_q;

endmodule

// ===== hdl/mdpq_ram.sv =====
// ----------------------------------------------------------------------------
// mdpq_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module mdpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
